// ===== design/bir_pkg.sv =====
// shared constants, types and helpers for the bilinear image scaler
`timescale 1ns / 1ps
package bir_pkg;

   localparam int MAX_HEIGHT   = 256;
   localparam int MAX_WIDTH    = 256;
   localparam int MAX_CHANNELS = 4;

   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int CH_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int IDX_BITS  = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
   localparam int SIZE_BITS = 9;

   // four banks split by row and column parity
   localparam int BANK_AW    = (ROW_BITS - 1) + (COL_BITS - 1) + CH_BITS;
   localparam int BANK_DEPTH = 1 << BANK_AW;

   localparam int COORD_BITS = 12;
   localparam int DST_BITS   = 13;
   localparam int SCALE_BITS = 25;
   localparam int U_BITS     = COORD_BITS + 1 + SCALE_BITS + 1;
   localparam int Q_BITS     = U_BITS - 17;
   localparam int FRAC_BITS  = 16;
   localparam int H_BITS     = 24;
   localparam int V_BITS     = 40;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      REG_SRC_HEIGHT = 3'd0,
      REG_SRC_WIDTH  = 3'd1,
      REG_CHANNELS   = 3'd2,
      REG_DST_HEIGHT = 3'd3,
      REG_DST_WIDTH  = 3'd4,
      REG_SCALE_Y    = 3'd5,
      REG_SCALE_X    = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] n0;
      logic [IDX_BITS-1:0] n1;
   } nbr_type;

   // saturate a size register to 1..hi
   function automatic logic [SIZE_BITS-1:0] sat_size(input logic [SIZE_BITS-1:0] v,
                                                    input logic [SIZE_BITS-1:0] hi);
      logic [SIZE_BITS-1:0] r;
      if (v == '0) r = SIZE_BITS'(1);
      else if (v > hi) r = hi;
      else r = v;
      return r;
   endfunction

   // q is floor index plus one; clamp both neighbours into 0..size-1
   function automatic nbr_type clamp_nbr(input logic [Q_BITS-1:0] q,
                                        input logic [SIZE_BITS-1:0] size);
      nbr_type r;
      logic [Q_BITS-1:0] lim;
      logic [Q_BITS-1:0] qm1;
      lim = Q_BITS'(size - SIZE_BITS'(1));
      qm1 = q - Q_BITS'(1);
      r.n1 = (q > lim) ? IDX_BITS'(lim) : IDX_BITS'(q);
      if (q == '0) r.n0 = '0;
      else r.n0 = (qm1 > lim) ? IDX_BITS'(lim) : IDX_BITS'(qm1);
      return r;
   endfunction

endpackage

// ===== design/bir_ram.sv =====
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps
module bir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/bilinear_image_resize.sv =====
// bilinear image scaler top level: csr block, coordinate map, banked store, blend pipeline
// a request beat is registered through stages 1, 2 and 3 and then the output register
// throughput: one beat per cycle unless stalled; four banks each serve one read per cycle
// a stalled output holds the whole pipeline; nothing is dropped or repeated
// reset clears valid bits and sets the registers to their defaults
// frame-store contents are undefined after reset until written
`timescale 1ns / 1ps
module bilinear_image_resize (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,  // row, col, channel, sample, zero pad
   input  logic                          req_tuser,  // command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // value
   output logic                          rsp_tuser,  // error
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bir_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [bir_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [bir_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   localparam int SB  = bir_pkg::SIZE_BITS;
   localparam int CB  = bir_pkg::CH_BITS;
   localparam int RB  = bir_pkg::ROW_BITS;
   localparam int LB  = bir_pkg::COL_BITS;
   localparam int UB  = bir_pkg::U_BITS;
   localparam int FB  = bir_pkg::FRAC_BITS;
   localparam int AW  = bir_pkg::BANK_AW;

   // ---------------- configuration registers ----------------
   logic [8:0]  src_height_ff, src_width_ff;
   logic [2:0]  channels_ff;
   logic [12:0] dst_height_ff, dst_width_ff;
   logic [24:0] scale_y_ff, scale_x_ff;
   logic        csr_wr;
   bir_pkg::reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = bir_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_height_ff <= 9'd256;
         src_width_ff  <= 9'd256;
         channels_ff   <= 3'd1;
         dst_height_ff <= 13'd256;
         dst_width_ff  <= 13'd256;
         scale_y_ff    <= 25'd65536;
         scale_x_ff    <= 25'd65536;
      end else if (csr_wr) begin
         case (csr_idx)
            bir_pkg::REG_SRC_HEIGHT: src_height_ff <= csr_pwdata[8:0];
            bir_pkg::REG_SRC_WIDTH:  src_width_ff  <= csr_pwdata[8:0];
            bir_pkg::REG_CHANNELS:   channels_ff   <= csr_pwdata[2:0];
            bir_pkg::REG_DST_HEIGHT: dst_height_ff <= csr_pwdata[12:0];
            bir_pkg::REG_DST_WIDTH:  dst_width_ff  <= csr_pwdata[12:0];
            bir_pkg::REG_SCALE_Y:    scale_y_ff    <= csr_pwdata[24:0];
            bir_pkg::REG_SCALE_X:    scale_x_ff    <= csr_pwdata[24:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         bir_pkg::REG_SRC_HEIGHT: csr_prdata = 32'(src_height_ff);
         bir_pkg::REG_SRC_WIDTH:  csr_prdata = 32'(src_width_ff);
         bir_pkg::REG_CHANNELS:   csr_prdata = 32'(channels_ff);
         bir_pkg::REG_DST_HEIGHT: csr_prdata = 32'(dst_height_ff);
         bir_pkg::REG_DST_WIDTH:  csr_prdata = 32'(dst_width_ff);
         bir_pkg::REG_SCALE_Y:    csr_prdata = 32'(scale_y_ff);
         bir_pkg::REG_SCALE_X:    csr_prdata = 32'(scale_x_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   logic [SB-1:0] sh, sw;
   logic [2:0]    nc;
   assign sh = bir_pkg::sat_size(src_height_ff, SB'(bir_pkg::MAX_HEIGHT));
   assign sw = bir_pkg::sat_size(src_width_ff, SB'(bir_pkg::MAX_WIDTH));
   assign nc = 3'(bir_pkg::sat_size(SB'(channels_ff), SB'(bir_pkg::MAX_CHANNELS)));

   // ---------------- pipeline control ----------------
   logic adv;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, out_vld_ff;

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 1: range check and coordinate products ----------------
   logic [11:0] in_row, in_col;
   logic [1:0]  in_ch;
   logic [7:0]  in_smp;
   logic        in_cmd;
   assign in_row = req_tdata[11:0];
   assign in_col = req_tdata[23:12];
   assign in_ch  = req_tdata[25:24];
   assign in_smp = req_tdata[33:26];
   assign in_cmd = req_tuser;

   logic          s1_req_ff, s1_err_ff, s1_wok_ff;
   logic [UB-1:0] s1_uy_ff, s1_ux_ff;
   logic [RB-1:0] s1_row_ff;
   logic [LB-1:0] s1_col_ff;
   logic [CB-1:0] s1_ch_ff;
   logic [7:0]    s1_smp_ff;
   logic          s1_err_in, s1_wok_in;
   logic [UB-1:0] s1_uy_in, s1_ux_in;

   assign s1_err_in = (13'(in_row) >= dst_height_ff) || (13'(in_col) >= dst_width_ff) ||
                      (3'(in_ch) >= nc);
   assign s1_wok_in = (in_row < 12'(sh)) && (in_col < 12'(sw)) && (3'(in_ch) < nc);
   // u = (2d+1)*scale + 2^16, the source position plus one in Q17
   assign s1_uy_in  = UB'({in_row, 1'b1}) * UB'(scale_y_ff) + UB'(65536);
   assign s1_ux_in  = UB'({in_col, 1'b1}) * UB'(scale_x_ff) + UB'(65536);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff <= in_cmd;
         s1_err_ff <= s1_err_in;
         s1_wok_ff <= s1_wok_in;
         s1_uy_ff  <= s1_uy_in;
         s1_ux_ff  <= s1_ux_in;
         s1_row_ff <= in_row[RB-1:0];
         s1_col_ff <= in_col[LB-1:0];
         s1_ch_ff  <= in_ch[CB-1:0];
         s1_smp_ff <= in_smp;
      end
   end

   // ---------------- stage 2: clamp, bank addressing, store access ----------------
   bir_pkg::nbr_type ny, nx;
   assign ny = bir_pkg::clamp_nbr(s1_uy_ff[UB-1:17], sh);
   assign nx = bir_pkg::clamp_nbr(s1_ux_ff[UB-1:17], sw);

   logic [RB-1:0] y0, y1, y_even, y_odd;
   logic [LB-1:0] x0, x1, x_even, x_odd;
   assign y0 = ny.n0[RB-1:0];
   assign y1 = ny.n1[RB-1:0];
   assign x0 = nx.n0[LB-1:0];
   assign x1 = nx.n1[LB-1:0];
   // neighbours differ by at most one, so each parity bank sees one of them
   assign y_even = y0[0] ? y1 : y0;
   assign y_odd  = y0[0] ? y0 : y1;
   assign x_even = x0[0] ? x1 : x0;
   assign x_odd  = x0[0] ? x0 : x1;

   logic [3:0]    bank_we;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr [4];
   logic [7:0]    rd_data [4];
   logic          do_write;

   assign do_write = adv && s1_vld_ff && !s1_req_ff && s1_wok_ff;
   assign wr_addr  = {s1_row_ff[RB-1:1], s1_col_ff[LB-1:1], s1_ch_ff};
   assign bank_we  = do_write ? (4'b0001 << {s1_row_ff[0], s1_col_ff[0]}) : 4'b0000;
   assign rd_addr[0] = {y_even[RB-1:1], x_even[LB-1:1], s1_ch_ff};
   assign rd_addr[1] = {y_even[RB-1:1], x_odd[LB-1:1],  s1_ch_ff};
   assign rd_addr[2] = {y_odd[RB-1:1],  x_even[LB-1:1], s1_ch_ff};
   assign rd_addr[3] = {y_odd[RB-1:1],  x_odd[LB-1:1],  s1_ch_ff};

   for (genvar g = 0; g < 4; g++) begin : g_bank
      bir_ram #(
         .WIDTH (8),
         .DEPTH (bir_pkg::BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[g]),
         .wr_addr (wr_addr),
         .wr_data (s1_smp_ff),
         .rd_en   (adv),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   logic          s2_req_ff, s2_err_ff;
   logic [FB-1:0] s2_fy_ff, s2_fx_ff;
   logic          s2_y0p_ff, s2_y1p_ff, s2_x0p_ff, s2_x1p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_req_ff <= s1_req_ff;
         s2_err_ff <= s1_err_ff;
         s2_fy_ff  <= s1_uy_ff[16:1];
         s2_fx_ff  <= s1_ux_ff[16:1];
         s2_y0p_ff <= y0[0];
         s2_y1p_ff <= y1[0];
         s2_x0p_ff <= x0[0];
         s2_x1p_ff <= x1[0];
      end
   end

   // ---------------- stage 3: horizontal blend ----------------
   logic [7:0]  pa, pb, pc, pd;
   logic [16:0] wx0, wx1;
   logic [bir_pkg::H_BITS-1:0] h0_in, h1_in, s3_h0_ff, s3_h1_ff;
   logic [FB-1:0] s3_fy_ff;
   logic          s3_req_ff, s3_err_ff;

   assign pa  = rd_data[{s2_y0p_ff, s2_x0p_ff}];
   assign pb  = rd_data[{s2_y0p_ff, s2_x1p_ff}];
   assign pc  = rd_data[{s2_y1p_ff, s2_x0p_ff}];
   assign pd  = rd_data[{s2_y1p_ff, s2_x1p_ff}];
   assign wx1 = 17'(s2_fx_ff);
   assign wx0 = 17'(65536) - wx1;
   assign h0_in = bir_pkg::H_BITS'(25'(pa) * 25'(wx0) + 25'(pb) * 25'(wx1));
   assign h1_in = bir_pkg::H_BITS'(25'(pc) * 25'(wx0) + 25'(pd) * 25'(wx1));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_h0_ff  <= h0_in;
         s3_h1_ff  <= h1_in;
         s3_fy_ff  <= s2_fy_ff;
         s3_req_ff <= s2_req_ff;
         s3_err_ff <= s2_err_ff;
      end
   end

   // ---------------- stage 4: vertical blend, round, saturate ----------------
   logic [16:0] wy0, wy1;
   logic [bir_pkg::V_BITS-1:0] v_sum;
   logic [8:0]  v_rnd;
   logic [7:0]  val_in, out_val_ff;
   logic        out_err_ff;

   assign wy1   = 17'(s3_fy_ff);
   assign wy0   = 17'(65536) - wy1;
   assign v_sum = bir_pkg::V_BITS'(s3_h0_ff) * bir_pkg::V_BITS'(wy0)
                + bir_pkg::V_BITS'(s3_h1_ff) * bir_pkg::V_BITS'(wy1)
                + bir_pkg::V_BITS'(40'h80000000);
   assign v_rnd  = 9'(v_sum[bir_pkg::V_BITS-1:32]);
   assign val_in = s3_err_ff ? 8'd0 : ((v_rnd > 9'd255) ? 8'd255 : v_rnd[7:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= s3_vld_ff && s3_req_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_val_ff <= val_in;
         out_err_ff <= s3_err_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tuser  = out_err_ff;

   // ---------------- checks ----------------
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("error beat carries nonzero value");

   a_one_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_we))
      else $error("more than one bank written");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv && s3_vld_ff |=> s3_vld_ff && $stable(s3_h0_ff))
      else $error("pipeline moved during stall");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      adv && s3_vld_ff && !s3_req_ff |=> !rsp_tvalid)
      else $error("write produced a result");
endmodule
